@@ rtl/cocc_pkg.sv @@
// shared constants, codes and controller/datapath interface types
`timescale 1ns / 1ps
`default_nettype none
package cocc_pkg;

  // channel count and sensor sample width
  localparam int NUM_CHANNELS = 6;
  localparam int SAMPLE_BITS  = 10;

  // fixed field widths
  localparam int OP_W     = 3;
  localparam int CH_W     = 3;
  localparam int RULE_W   = 3;
  localparam int DATA_W   = 32;
  localparam int SAMPLE_W = 10;
  localparam int LEFT_W   = 10;

  // channel record index width
  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // divide by 1000 through reciprocal multiply, exact for any 32-bit value
  localparam int                 MS_PER_SEC = 1000;
  localparam logic [DATA_W-1:0]  DIV_MAGIC  = 32'h10624DD3;
  localparam int                 DIV_SHIFT  = 38;
  localparam int                 Q_W        = 23;

  // mask applied to the analog sample
  localparam logic [SAMPLE_W-1:0] SAMPLE_MASK =
    SAMPLE_W'((33'd1 << SAMPLE_BITS) - 33'd1);

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_EVAL   = 3'd0,
    OP_SET    = 3'd1,
    OP_TOGGLE = 3'd2,
    OP_KILL   = 3'd3,
    OP_READ   = 3'd4
  } op_t;

  // rule codes
  localparam logic [RULE_W-1:0] RULE_TIMER  = 3'd0;
  localparam logic [RULE_W-1:0] RULE_PULSE  = 3'd1;
  localparam logic [RULE_W-1:0] RULE_RISING = 3'd2;
  localparam logic [RULE_W-1:0] RULE_ABOVE  = 3'd3;
  localparam logic [RULE_W-1:0] RULE_BELOW  = 3'd4;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic load;
    logic exec;
    logic pin;
    logic elap;
    logic mul;
    logic apply;
    logic check;
    logic respond;
    logic phase;
  } cocc_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic op_eval;
    logic in_range;
    logic enabled;
    logic on_off;
    logic rule_timer;
    logic out_free;
  } cocc_stat_t;

endpackage
`default_nettype wire

@@ rtl/cocc_dp.sv @@
// datapath: channel records, working copy, rule arithmetic and result register
`timescale 1ns / 1ps
`default_nettype none
module cocc_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire cocc_pkg::cocc_cmd_t           cmd,
  output cocc_pkg::cocc_stat_t               stat,
  input  wire logic [cocc_pkg::OP_W-1:0]     in_op,
  input  wire logic [cocc_pkg::CH_W-1:0]     in_channel,
  input  wire logic [cocc_pkg::DATA_W-1:0]   in_now_ms,
  input  wire logic                          in_pin_level,
  input  wire logic [cocc_pkg::SAMPLE_W-1:0] in_analog_sample,
  input  wire logic [cocc_pkg::RULE_W-1:0]   in_cond_on,
  input  wire logic [cocc_pkg::RULE_W-1:0]   in_cond_off,
  input  wire logic [cocc_pkg::DATA_W-1:0]   in_value_on,
  input  wire logic [cocc_pkg::DATA_W-1:0]   in_value_off,
  input  wire logic                          in_initial_state,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [cocc_pkg::CH_W-1:0]          out_channel_out,
  output logic                               out_active,
  output logic                               out_out_level,
  output logic                               out_cur_state,
  output logic [cocc_pkg::RULE_W-1:0]        out_rule_on,
  output logic [cocc_pkg::RULE_W-1:0]        out_rule_off,
  output logic [cocc_pkg::DATA_W-1:0]        out_target_on,
  output logic [cocc_pkg::DATA_W-1:0]        out_target_off,
  output logic [cocc_pkg::DATA_W-1:0]        out_progress
);

  localparam int NCH = cocc_pkg::NUM_CHANNELS;
  localparam int DW  = cocc_pkg::DATA_W;
  localparam int RW  = cocc_pkg::RULE_W;
  localparam int LW  = cocc_pkg::LEFT_W;
  localparam logic [DW-1:0] SAT_MAX = '1;

  // channel record store
  logic          en_mem   [NCH];
  logic          onoff_mem[NCH];
  logic [RW-1:0] ron_mem  [NCH];
  logic [RW-1:0] roff_mem [NCH];
  logic [DW-1:0] ton_mem  [NCH];
  logic [DW-1:0] toff_mem [NCH];
  logic [DW-1:0] prog_mem [NCH];
  logic [DW-1:0] last_mem [NCH];
  logic [LW-1:0] left_mem [NCH];
  logic          lvl_mem  [NCH];
  logic          pin_mem  [NCH];

  // captured request
  logic [cocc_pkg::OP_W-1:0]     op_r;
  logic [cocc_pkg::CH_W-1:0]     ch_r;
  logic [DW-1:0]                 now_r;
  logic                          lvl_r;
  logic [cocc_pkg::SAMPLE_W-1:0] smp_r;
  logic [RW-1:0]                 con_r;
  logic [RW-1:0]                 coff_r;
  logic [DW-1:0]                 von_r;
  logic [DW-1:0]                 voff_r;
  logic                          init_r;

  // working copy of the addressed channel
  logic          w_en_r;
  logic          w_onoff_r;
  logic [RW-1:0] w_ron_r;
  logic [RW-1:0] w_roff_r;
  logic [DW-1:0] w_ton_r;
  logic [DW-1:0] w_toff_r;
  logic [DW-1:0] w_prog_r;
  logic [DW-1:0] w_last_r;
  logic [LW-1:0] w_left_r;
  logic          w_lvl_r;
  logic          w_pin_r;

  // timer arithmetic pipeline
  logic [DW-1:0]   elap_r;
  logic [2*DW-1:0] prod_r;

  logic                          out_valid_r;
  logic [cocc_pkg::IDX_W-1:0]    idx;
  logic                          in_range;
  logic [RW-1:0]                 rule_sel;
  logic [DW-1:0]                 tgt_sel;
  logic [cocc_pkg::Q_W-1:0]      q;
  logic [DW-1:0]                 q_ms;
  logic [LW-1:0]                 rem;
  logic [DW:0]                   sum_q;
  logic [DW:0]                   sum_1;
  logic [DW-1:0]                 sat_q;
  logic [DW-1:0]                 sat_1;
  logic [DW:0]                   twice;
  logic [DW:0]                   diff;
  logic [cocc_pkg::SAMPLE_W-1:0] smp;
  logic [DW-1:0]                 a_prog;
  logic [DW-1:0]                 a_last;
  logic [LW-1:0]                 a_left;
  logic                          a_lvl;
  logic                          hit;

  assign idx      = cocc_pkg::IDX_W'(ch_r);
  assign in_range = (int'(ch_r) < NCH);
  assign smp      = smp_r & cocc_pkg::SAMPLE_MASK;
  assign rule_sel = cmd.phase ? w_roff_r : w_ron_r;
  assign tgt_sel  = cmd.phase ? w_toff_r : w_ton_r;

  // status toward the controller
  assign stat.op_eval    = (op_r == cocc_pkg::OP_EVAL);
  assign stat.in_range   = in_range;
  assign stat.enabled    = w_en_r;
  assign stat.on_off     = w_onoff_r;
  assign stat.rule_timer = (rule_sel == cocc_pkg::RULE_TIMER);
  assign stat.out_free   = !out_valid_r || out_ready;

  // quotient and remainder of elapsed time by one second
  assign q     = prod_r[cocc_pkg::DIV_SHIFT +: cocc_pkg::Q_W];
  assign q_ms  = DW'(q) * DW'(cocc_pkg::MS_PER_SEC);
  assign rem   = elap_r[LW-1:0] - q_ms[LW-1:0];

  // saturating progress increments
  assign sum_q = {1'b0, w_prog_r} + {1'b0, DW'(q)};
  assign sum_1 = {1'b0, w_prog_r} + (DW+1)'(1);
  assign sat_q = sum_q[DW] ? SAT_MAX : sum_q[DW-1:0];
  assign sat_1 = sum_1[DW] ? SAT_MAX : sum_1[DW-1:0];

  // below-threshold progress
  assign twice = {tgt_sel, 1'b0};
  assign diff  = twice - (DW+1)'(smp);

  // rule update of progress and timing state
  always_comb begin
    a_prog = w_prog_r;
    a_last = w_last_r;
    a_left = w_left_r;
    a_lvl  = w_lvl_r;
    unique case (rule_sel)
      cocc_pkg::RULE_TIMER: begin
        if (elap_r >= DW'(cocc_pkg::MS_PER_SEC)) begin
          a_last = now_r;
          a_left = rem;
          a_prog = sat_q;
        end
      end
      cocc_pkg::RULE_PULSE, cocc_pkg::RULE_RISING: begin
        if (lvl_r && !w_lvl_r) begin
          a_lvl = 1'b1;
          if (rule_sel == cocc_pkg::RULE_RISING) a_prog = sat_1;
        end else if (!lvl_r && w_lvl_r) begin
          a_lvl = 1'b0;
          if (rule_sel == cocc_pkg::RULE_PULSE) a_prog = sat_1;
        end
      end
      cocc_pkg::RULE_ABOVE: begin
        a_prog = DW'(smp);
      end
      cocc_pkg::RULE_BELOW: begin
        if (twice <= (DW+1)'(smp)) begin
          a_prog = '0;
        end else if (diff[DW]) begin
          a_prog = SAT_MAX;
        end else begin
          a_prog = diff[DW-1:0];
        end
      end
      default: begin
        a_prog = w_prog_r;
      end
    endcase
  end

  // target reached
  assign hit = (w_prog_r >= tgt_sel);

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_op;
      ch_r   <= in_channel;
      now_r  <= in_now_ms;
      lvl_r  <= in_pin_level;
      smp_r  <= in_analog_sample;
      con_r  <= in_cond_on;
      coff_r <= in_cond_off;
      von_r  <= in_value_on;
      voff_r <= in_value_off;
      init_r <= in_initial_state;
    end
  end

  // working copy: load, operation, rule steps
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      w_en_r    <= en_mem[idx];
      w_onoff_r <= onoff_mem[idx];
      w_ron_r   <= ron_mem[idx];
      w_roff_r  <= roff_mem[idx];
      w_ton_r   <= ton_mem[idx];
      w_toff_r  <= toff_mem[idx];
      w_prog_r  <= prog_mem[idx];
      w_last_r  <= last_mem[idx];
      w_left_r  <= left_mem[idx];
      w_lvl_r   <= lvl_mem[idx];
      w_pin_r   <= pin_mem[idx];
    end else if (cmd.exec) begin
      unique case (op_r)
        cocc_pkg::OP_SET: begin
          w_en_r    <= 1'b1;
          w_ron_r   <= con_r;
          w_roff_r  <= coff_r;
          w_ton_r   <= von_r;
          w_toff_r  <= voff_r;
          w_onoff_r <= init_r;
          w_prog_r  <= '0;
          w_last_r  <= now_r;
          w_left_r  <= '0;
          w_lvl_r   <= 1'b0;
        end
        cocc_pkg::OP_TOGGLE: begin
          w_prog_r  <= '0;
          w_onoff_r <= !w_onoff_r;
          w_lvl_r   <= 1'b0;
          w_last_r  <= now_r;
        end
        cocc_pkg::OP_KILL: begin
          w_en_r    <= 1'b0;
          w_onoff_r <= 1'b0;
          w_ron_r   <= '0;
          w_roff_r  <= '0;
          w_ton_r   <= '0;
          w_toff_r  <= '0;
          w_prog_r  <= '0;
          w_last_r  <= now_r;
          w_left_r  <= '0;
          w_lvl_r   <= 1'b0;
          w_pin_r   <= 1'b0;
        end
        default: begin
          w_en_r <= w_en_r;
        end
      endcase
    end else if (cmd.pin) begin
      w_pin_r <= w_onoff_r;
    end else if (cmd.apply) begin
      w_prog_r <= a_prog;
      w_last_r <= a_last;
      w_left_r <= a_left;
      w_lvl_r  <= a_lvl;
    end else if (cmd.check && hit) begin
      w_onoff_r <= !cmd.phase;
      w_prog_r  <= '0;
      w_last_r  <= now_r;
      w_left_r  <= '0;
      w_lvl_r   <= 1'b0;
    end
  end

  // elapsed time and reciprocal product
  always_ff @(posedge clk) begin
    if (cmd.elap) begin
      elap_r <= now_r + DW'(w_left_r) - w_last_r;
    end
    if (cmd.mul) begin
      prod_r <= (2*DW)'(elap_r) * (2*DW)'(cocc_pkg::DIV_MAGIC);
    end
  end

  // channel store write-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NCH; i++) begin
        en_mem[i]    <= 1'b0;
        onoff_mem[i] <= 1'b0;
        ron_mem[i]   <= '0;
        roff_mem[i]  <= '0;
        ton_mem[i]   <= '0;
        toff_mem[i]  <= '0;
        prog_mem[i]  <= '0;
        last_mem[i]  <= '0;
        left_mem[i]  <= '0;
        lvl_mem[i]   <= 1'b0;
        pin_mem[i]   <= 1'b0;
      end
    end else if (cmd.respond && in_range) begin
      en_mem[idx]    <= w_en_r;
      onoff_mem[idx] <= w_onoff_r;
      ron_mem[idx]   <= w_ron_r;
      roff_mem[idx]  <= w_roff_r;
      ton_mem[idx]   <= w_ton_r;
      toff_mem[idx]  <= w_toff_r;
      prog_mem[idx]  <= w_prog_r;
      last_mem[idx]  <= w_last_r;
      left_mem[idx]  <= w_left_r;
      lvl_mem[idx]   <= w_lvl_r;
      pin_mem[idx]   <= w_pin_r;
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.respond) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload: channel echoed, other fields zero for a channel out of range
  always_ff @(posedge clk) begin
    if (cmd.respond) begin
      out_channel_out <= ch_r;
      out_active      <= in_range && w_en_r;
      out_out_level   <= in_range && w_pin_r;
      out_cur_state   <= in_range && w_onoff_r;
      out_rule_on     <= in_range ? w_ron_r  : '0;
      out_rule_off    <= in_range ? w_roff_r : '0;
      out_target_on   <= in_range ? w_ton_r  : '0;
      out_target_off  <= in_range ? w_toff_r : '0;
      out_progress    <= in_range ? w_prog_r : '0;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

@@ rtl/cocc_ctrl.sv @@
// controller: sequences one request through load, operation and rule passes
`timescale 1ns / 1ps
`default_nettype none
module cocc_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire cocc_pkg::cocc_stat_t stat,
  output cocc_pkg::cocc_cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_EXEC,
    S_PIN,
    S_SEL,
    S_ELAP,
    S_MUL,
    S_APPLY,
    S_CHECK,
    S_RESP
  } state_t;

  state_t state_r;
  logic   phase_r;

  assign in_ready = (state_r == S_IDLE);

  // commands decoded from state
  always_comb begin
    cmd         = '0;
    cmd.phase   = phase_r;
    cmd.capture = (state_r == S_IDLE) && in_valid;
    cmd.load    = (state_r == S_LOAD);
    cmd.exec    = (state_r == S_EXEC);
    cmd.pin     = (state_r == S_PIN) && stat.enabled;
    cmd.elap    = (state_r == S_ELAP);
    cmd.mul     = (state_r == S_MUL);
    cmd.apply   = (state_r == S_APPLY);
    cmd.check   = (state_r == S_CHECK);
    cmd.respond = (state_r == S_RESP) && stat.out_free;
  end

  // state and rule phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) state_r <= S_LOAD;
        end
        S_LOAD: begin
          phase_r <= 1'b0;
          priority if (!stat.in_range) state_r <= S_RESP;
          else if (stat.op_eval)       state_r <= S_PIN;
          else                         state_r <= S_EXEC;
        end
        S_EXEC: begin
          state_r <= S_RESP;
        end
        S_PIN: begin
          state_r <= stat.enabled ? S_SEL : S_RESP;
        end
        // turn-on pass applies when off, turn-off pass when on
        S_SEL: begin
          priority if (stat.on_off == phase_r) begin
            state_r <= stat.rule_timer ? S_ELAP : S_APPLY;
          end else if (!phase_r) begin
            phase_r <= 1'b1;
          end else begin
            state_r <= S_RESP;
          end
        end
        S_ELAP: begin
          state_r <= S_MUL;
        end
        S_MUL: begin
          state_r <= S_APPLY;
        end
        S_APPLY: begin
          state_r <= S_CHECK;
        end
        S_CHECK: begin
          if (!phase_r) begin
            phase_r <= 1'b1;
            state_r <= S_SEL;
          end else begin
            state_r <= S_RESP;
          end
        end
        S_RESP: begin
          if (stat.out_free) state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/conditional_output_channel_controller.sv @@
// top level: six-channel conditional output controller, one request at a time
// read, set, toggle, kill: request loaded, operation applied, then the result registered
// channel out of range: the load step goes straight to the result
// evaluate: pin update, then up to two rule passes of up to five steps each,
// a timer pass running elapsed add, reciprocal multiply by 1/1000, update and compare
// synchronous active-low reset clears every channel record and drives all pins low
`timescale 1ns / 1ps
`default_nettype none
module conditional_output_channel_controller (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [cocc_pkg::OP_W-1:0]     in_op,
  input  wire logic [cocc_pkg::CH_W-1:0]     in_channel,
  input  wire logic [cocc_pkg::DATA_W-1:0]   in_now_ms,
  input  wire logic                          in_pin_level,
  input  wire logic [cocc_pkg::SAMPLE_W-1:0] in_analog_sample,
  input  wire logic [cocc_pkg::RULE_W-1:0]   in_cond_on,
  input  wire logic [cocc_pkg::RULE_W-1:0]   in_cond_off,
  input  wire logic [cocc_pkg::DATA_W-1:0]   in_value_on,
  input  wire logic [cocc_pkg::DATA_W-1:0]   in_value_off,
  input  wire logic                          in_initial_state,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [cocc_pkg::CH_W-1:0]          out_channel_out,
  output logic                               out_active,
  output logic                               out_out_level,
  output logic                               out_cur_state,
  output logic [cocc_pkg::RULE_W-1:0]        out_rule_on,
  output logic [cocc_pkg::RULE_W-1:0]        out_rule_off,
  output logic [cocc_pkg::DATA_W-1:0]        out_target_on,
  output logic [cocc_pkg::DATA_W-1:0]        out_target_off,
  output logic [cocc_pkg::DATA_W-1:0]        out_progress
);

  cocc_pkg::cocc_cmd_t  cmd;
  cocc_pkg::cocc_stat_t stat;

  // sequencer
  cocc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // channel records and arithmetic
  cocc_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_op            (in_op),
    .in_channel       (in_channel),
    .in_now_ms        (in_now_ms),
    .in_pin_level     (in_pin_level),
    .in_analog_sample (in_analog_sample),
    .in_cond_on       (in_cond_on),
    .in_cond_off      (in_cond_off),
    .in_value_on      (in_value_on),
    .in_value_off     (in_value_off),
    .in_initial_state (in_initial_state),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_channel_out  (out_channel_out),
    .out_active       (out_active),
    .out_out_level    (out_out_level),
    .out_cur_state    (out_cur_state),
    .out_rule_on      (out_rule_on),
    .out_rule_off     (out_rule_off),
    .out_target_on    (out_target_on),
    .out_target_off   (out_target_off),
    .out_progress     (out_progress)
  );

endmodule
`default_nettype wire

@@ tb/sv/tb.sv @@
// testbench for the conditional output channel controller with a status predictor
`timescale 1ns / 1ps
module tb;

  // package constants and codes
  localparam int                           NUM_CHANNELS = cocc_pkg::NUM_CHANNELS;
  localparam int                           OP_W         = cocc_pkg::OP_W;
  localparam int                           CH_W         = cocc_pkg::CH_W;
  localparam int                           RULE_W       = cocc_pkg::RULE_W;
  localparam int                           DATA_W       = cocc_pkg::DATA_W;
  localparam int                           SAMPLE_W     = cocc_pkg::SAMPLE_W;
  localparam int                           LEFT_W       = cocc_pkg::LEFT_W;
  localparam int                           MS_PER_SEC   = cocc_pkg::MS_PER_SEC;
  localparam logic [SAMPLE_W-1:0]          SAMPLE_MASK  = cocc_pkg::SAMPLE_MASK;
  localparam logic [OP_W-1:0]              OP_EVAL      = cocc_pkg::OP_EVAL;
  localparam logic [OP_W-1:0]              OP_SET       = cocc_pkg::OP_SET;
  localparam logic [OP_W-1:0]              OP_TOGGLE    = cocc_pkg::OP_TOGGLE;
  localparam logic [OP_W-1:0]              OP_KILL      = cocc_pkg::OP_KILL;
  localparam logic [OP_W-1:0]              OP_READ      = cocc_pkg::OP_READ;
  localparam logic [RULE_W-1:0]            RULE_TIMER   = cocc_pkg::RULE_TIMER;
  localparam logic [RULE_W-1:0]            RULE_PULSE   = cocc_pkg::RULE_PULSE;
  localparam logic [RULE_W-1:0]            RULE_RISING  = cocc_pkg::RULE_RISING;
  localparam logic [RULE_W-1:0]            RULE_ABOVE   = cocc_pkg::RULE_ABOVE;
  localparam logic [RULE_W-1:0]            RULE_BELOW   = cocc_pkg::RULE_BELOW;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 12;
  localparam int QUIET_LIMIT   = 3000;
  localparam int DRAIN_CYCLES  = 30;
  localparam int STEADY_ITEMS  = 100;
  localparam int RANDOM_ITEMS  = 800;

  // codes with no meaning in the block
  localparam logic [OP_W-1:0]   OP_SPARE  = 3'd5;
  localparam logic [RULE_W-1:0] RULE_NONE = 3'd7;

  typedef struct {
    logic [OP_W-1:0]     op;
    logic [CH_W-1:0]     ch;
    logic [DATA_W-1:0]   now;
    logic                pin;
    logic [SAMPLE_W-1:0] sample;
    logic [RULE_W-1:0]   cond_on;
    logic [RULE_W-1:0]   cond_off;
    logic [DATA_W-1:0]   value_on;
    logic [DATA_W-1:0]   value_off;
    logic                init;
  } request_t;

  typedef struct {
    logic [CH_W-1:0]   channel;
    logic              active;
    logic              level;
    logic              state;
    logic [RULE_W-1:0] rule_on;
    logic [RULE_W-1:0] rule_off;
    logic [DATA_W-1:0] target_on;
    logic [DATA_W-1:0] target_off;
    logic [DATA_W-1:0] progress;
  } status_t;

  // dut signals
  logic                clk              = 1'b0;
  logic                rst_n            = 1'b0;
  logic                in_valid         = 1'b0;
  logic                in_ready;
  logic [OP_W-1:0]     in_op            = '0;
  logic [CH_W-1:0]     in_channel       = '0;
  logic [DATA_W-1:0]   in_now_ms        = '0;
  logic                in_pin_level     = 1'b0;
  logic [SAMPLE_W-1:0] in_analog_sample = '0;
  logic [RULE_W-1:0]   in_cond_on       = '0;
  logic [RULE_W-1:0]   in_cond_off      = '0;
  logic [DATA_W-1:0]   in_value_on      = '0;
  logic [DATA_W-1:0]   in_value_off     = '0;
  logic                in_initial_state = 1'b0;
  logic                out_valid;
  logic                out_ready        = 1'b1;
  logic [CH_W-1:0]     out_channel_out;
  logic                out_active;
  logic                out_out_level;
  logic                out_cur_state;
  logic [RULE_W-1:0]   out_rule_on;
  logic [RULE_W-1:0]   out_rule_off;
  logic [DATA_W-1:0]   out_target_on;
  logic [DATA_W-1:0]   out_target_off;
  logic [DATA_W-1:0]   out_progress;

  // predicted channel records
  bit                ch_enabled    [NUM_CHANNELS];
  bit                ch_on         [NUM_CHANNELS];
  bit [RULE_W-1:0]   ch_rule_on    [NUM_CHANNELS];
  bit [RULE_W-1:0]   ch_rule_off   [NUM_CHANNELS];
  bit [DATA_W-1:0]   ch_target_on  [NUM_CHANNELS];
  bit [DATA_W-1:0]   ch_target_off [NUM_CHANNELS];
  bit [DATA_W-1:0]   ch_progress   [NUM_CHANNELS];
  bit [DATA_W-1:0]   ch_last       [NUM_CHANNELS];
  bit [LEFT_W-1:0]   ch_leftover   [NUM_CHANNELS];
  bit                ch_seen       [NUM_CHANNELS];
  bit                ch_pin        [NUM_CHANNELS];

  status_t           pending_status[$];
  int                mismatches        = 0;
  int                requests_in_range = 0;
  int                quiet_cycles      = 0;
  int                ready_hold        = 0;
  bit                steady            = 1'b0;
  logic [DATA_W-1:0] clock_ms          = '0;

  conditional_output_channel_controller i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_channel       (in_channel),
    .in_now_ms        (in_now_ms),
    .in_pin_level     (in_pin_level),
    .in_analog_sample (in_analog_sample),
    .in_cond_on       (in_cond_on),
    .in_cond_off      (in_cond_off),
    .in_value_on      (in_value_on),
    .in_value_off     (in_value_off),
    .in_initial_state (in_initial_state),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_channel_out  (out_channel_out),
    .out_active       (out_active),
    .out_out_level    (out_out_level),
    .out_cur_state    (out_cur_state),
    .out_rule_on      (out_rule_on),
    .out_rule_off     (out_rule_off),
    .out_target_on    (out_target_on),
    .out_target_off   (out_target_off),
    .out_progress     (out_progress)
  );

  // clock
  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // saturating 32-bit add
  function automatic logic [DATA_W-1:0] sat_sum(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
    logic [DATA_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DATA_W] ? '1 : s[DATA_W-1:0];
  endfunction

  // progress update of one rule
  task automatic step_rule(input int c, input logic [RULE_W-1:0] rule,
                           input logic [DATA_W-1:0] target, input logic [DATA_W-1:0] now,
                           input logic lvl, input logic [SAMPLE_W-1:0] sample);
    logic [DATA_W-1:0] elapsed;
    logic [DATA_W:0]   twice;
    logic [DATA_W:0]   wide_sample;
    wide_sample = (DATA_W+1)'(sample);
    case (rule)
      RULE_TIMER: begin
        elapsed = now + DATA_W'(ch_leftover[c]) - ch_last[c];
        if (elapsed >= DATA_W'(MS_PER_SEC)) begin
          ch_last[c]     = now;
          ch_leftover[c] = LEFT_W'(elapsed % DATA_W'(MS_PER_SEC));
          ch_progress[c] = sat_sum(ch_progress[c], elapsed / DATA_W'(MS_PER_SEC));
        end
      end
      RULE_PULSE, RULE_RISING: begin
        if (lvl && !ch_seen[c]) begin
          ch_seen[c] = 1'b1;
          if (rule == RULE_RISING) ch_progress[c] = sat_sum(ch_progress[c], DATA_W'(1));
        end else if (!lvl && ch_seen[c]) begin
          ch_seen[c] = 1'b0;
          if (rule == RULE_PULSE) ch_progress[c] = sat_sum(ch_progress[c], DATA_W'(1));
        end
      end
      RULE_ABOVE: ch_progress[c] = DATA_W'(sample);
      RULE_BELOW: begin
        twice = {target, 1'b0};
        if (twice <= wide_sample) ch_progress[c] = '0;
        else if (twice - wide_sample > {1'b0, {DATA_W{1'b1}}}) ch_progress[c] = '1;
        else ch_progress[c] = DATA_W'(twice - wide_sample);
      end
      default: ;
    endcase
  endtask

  // switch the channel and restart progress
  task automatic switch_channel(input int c, input bit st, input logic [DATA_W-1:0] now);
    ch_on[c]       = st;
    ch_progress[c] = '0;
    ch_last[c]     = now;
    ch_leftover[c] = '0;
    ch_seen[c]     = 1'b0;
  endtask

  // apply one request to the predicted records and build the expected status
  task automatic predict_status(input request_t r, output status_t s);
    int                  c;
    logic [SAMPLE_W-1:0] sample;
    s = '{default: '0};
    s.channel = r.ch;
    c = int'(r.ch);
    if (c >= NUM_CHANNELS) return;
    sample = r.sample & SAMPLE_MASK;
    case (r.op)
      OP_EVAL: if (ch_enabled[c]) begin
        ch_pin[c] = ch_on[c];
        if (!ch_on[c]) begin
          step_rule(c, ch_rule_on[c], ch_target_on[c], r.now, r.pin, sample);
          if (ch_progress[c] >= ch_target_on[c]) switch_channel(c, 1'b1, r.now);
        end
        if (ch_on[c]) begin
          step_rule(c, ch_rule_off[c], ch_target_off[c], r.now, r.pin, sample);
          if (ch_progress[c] >= ch_target_off[c]) switch_channel(c, 1'b0, r.now);
        end
      end
      OP_SET: begin
        ch_enabled[c]    = 1'b1;
        ch_rule_on[c]    = r.cond_on;
        ch_rule_off[c]   = r.cond_off;
        ch_target_on[c]  = r.value_on;
        ch_target_off[c] = r.value_off;
        switch_channel(c, r.init, r.now);
      end
      OP_TOGGLE: begin
        ch_progress[c] = '0;
        ch_on[c]       = ~ch_on[c];
        ch_seen[c]     = 1'b0;
        ch_last[c]     = r.now;
      end
      OP_KILL: begin
        ch_enabled[c]    = 1'b0;
        ch_rule_on[c]    = '0;
        ch_rule_off[c]   = '0;
        ch_target_on[c]  = '0;
        ch_target_off[c] = '0;
        ch_pin[c]        = 1'b0;
        switch_channel(c, 1'b0, r.now);
      end
      default: ;
    endcase
    s.active     = ch_enabled[c];
    s.level      = ch_pin[c];
    s.state      = ch_on[c];
    s.rule_on    = ch_rule_on[c];
    s.rule_off   = ch_rule_off[c];
    s.target_on  = ch_target_on[c];
    s.target_off = ch_target_off[c];
    s.progress   = ch_progress[c];
  endtask

  // idle length: mostly short, a few long
  function automatic int idle_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 85) return $urandom_range(0, 2);
    if (roll < 96) return $urandom_range(3, 16);
    return $urandom_range(20, 60);
  endfunction

  // drive one request, wait for acceptance, record its expected status
  task automatic send_request(input request_t r);
    status_t expected;
    int      gap;
    in_valid         <= 1'b1;
    in_op            <= r.op;
    in_channel       <= r.ch;
    in_now_ms        <= r.now;
    in_pin_level     <= r.pin;
    in_analog_sample <= r.sample;
    in_cond_on       <= r.cond_on;
    in_cond_off      <= r.cond_off;
    in_value_on      <= r.value_on;
    in_value_off     <= r.value_off;
    in_initial_state <= r.init;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_status(r, expected);
    pending_status.push_back(expected);
    if (r.ch < NUM_CHANNELS) requests_in_range++;
    gap = (steady || $urandom_range(0, 1) == 0) ? 0 : idle_length();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // request with random payload in the fields the op does not use
  function automatic request_t make_request(logic [OP_W-1:0] op, logic [CH_W-1:0] ch);
    request_t r;
    r.op        = op;
    r.ch        = ch;
    r.now       = clock_ms;
    r.pin       = 1'($urandom_range(0, 1));
    r.sample    = SAMPLE_W'($urandom());
    r.cond_on   = RULE_W'($urandom());
    r.cond_off  = RULE_W'($urandom());
    r.value_on  = $urandom();
    r.value_off = $urandom();
    r.init      = 1'($urandom_range(0, 1));
    return r;
  endfunction

  task automatic do_op(input logic [OP_W-1:0] op, input logic [CH_W-1:0] ch);
    send_request(make_request(op, ch));
  endtask

  task automatic set_channel(input logic [CH_W-1:0] ch, input logic [RULE_W-1:0] c_on,
                             input logic [RULE_W-1:0] c_off, input logic [DATA_W-1:0] v_on,
                             input logic [DATA_W-1:0] v_off, input logic init);
    request_t r;
    r           = make_request(OP_SET, ch);
    r.cond_on   = c_on;
    r.cond_off  = c_off;
    r.value_on  = v_on;
    r.value_off = v_off;
    r.init      = init;
    send_request(r);
  endtask

  task automatic eval_channel(input logic [CH_W-1:0] ch, input logic pin,
                              input logic [SAMPLE_W-1:0] sample);
    request_t r;
    r        = make_request(OP_EVAL, ch);
    r.pin    = pin;
    r.sample = sample;
    send_request(r);
  endtask

  // time stamp steps: mostly sub-second, some seconds, now and then a jump anywhere
  task automatic advance_clock();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) clock_ms += $urandom_range(0, 1500);
    else if (roll < 97) clock_ms += $urandom_range(1500, 8000);
    else clock_ms = $urandom();
  endtask

  function automatic logic [RULE_W-1:0] pick_rule();
    if ($urandom_range(0, 9) == 0) return RULE_W'($urandom_range(RULE_BELOW + 1, RULE_NONE));
    return RULE_W'($urandom_range(RULE_TIMER, RULE_BELOW));
  endfunction

  // targets small enough that the rules fire within a sequence
  function automatic logic [DATA_W-1:0] pick_target(logic [RULE_W-1:0] rule);
    if ($urandom_range(0, 19) == 0) return $urandom();
    case (rule)
      RULE_TIMER:              return $urandom_range(0, 5);
      RULE_PULSE, RULE_RISING: return $urandom_range(0, 4);
      RULE_ABOVE, RULE_BELOW:  return $urandom_range(0, 1023);
      default:                 return $urandom_range(0, 2);
    endcase
  endfunction

  // set one channel, then run evaluates on it and on other channels with other ops mixed in
  task automatic run_sequence();
    logic [CH_W-1:0]   ch;
    logic [RULE_W-1:0] r_on;
    logic [RULE_W-1:0] r_off;
    logic              pin;
    int                roll;
    ch    = CH_W'($urandom_range(0, NUM_CHANNELS - 1));
    r_on  = pick_rule();
    r_off = pick_rule();
    pin   = 1'b0;
    advance_clock();
    set_channel(ch, r_on, r_off, pick_target(r_on), pick_target(r_off),
                1'($urandom_range(0, 1)));
    repeat ($urandom_range(4, 14)) begin
      advance_clock();
      roll = $urandom_range(0, 99);
      if (roll < 6) do_op(OP_TOGGLE, ch);
      else if (roll < 9) do_op(OP_READ, ch);
      else if (roll < 11) do_op(OP_KILL, ch);
      else if (roll < 13) do_op(OP_W'($urandom_range(OP_SPARE, {OP_W{1'b1}})), ch);
      else if (roll < 15) do_op(OP_W'($urandom()),
                                CH_W'($urandom_range(NUM_CHANNELS, {CH_W{1'b1}})));
      else begin
        if ($urandom_range(0, 2) != 0) pin = ~pin;
        if (roll < 30) eval_channel(CH_W'($urandom_range(0, NUM_CHANNELS - 1)), pin,
                                    SAMPLE_W'($urandom()));
        else eval_channel(ch, pin, SAMPLE_W'($urandom()));
      end
    end
  endtask

  // fully random request
  function automatic request_t noise_request();
    request_t r;
    r = make_request(OP_W'($urandom()), CH_W'($urandom()));
    if ($urandom_range(0, 1) == 0) r.now = $urandom();
    return r;
  endfunction

  // status after reset, out-of-range channel, spare op, evaluate and toggle of a disabled channel
  task automatic test_reset_readback();
    do_op(OP_READ, CH_W'(0));
    do_op(OP_READ, {CH_W{1'b1}});
    do_op(OP_SPARE, CH_W'(5));
    do_op(OP_EVAL, CH_W'(1));
    do_op(OP_TOGGLE, CH_W'(2));
    do_op(OP_READ, CH_W'(2));
  endtask

  // each rule at its extremes
  task automatic test_rule_corners();
    // timer across the time stamp wrap, two seconds at once
    clock_ms = 32'hFFFF_FF00;
    set_channel(CH_W'(0), RULE_TIMER, RULE_NONE, 2, '1, 1'b0);
    clock_ms += 2500;
    eval_channel(CH_W'(0), 1'b0, '0);
    // below rule saturating high to turn on, then at zero to turn off in one step
    set_channel(CH_W'(1), RULE_BELOW, RULE_BELOW, '1, '0, 1'b0);
    eval_channel(CH_W'(1), 1'b0, '0);
    // rising edge turns on, end of the high pulse turns off
    set_channel(CH_W'(2), RULE_RISING, RULE_PULSE, 1, 1, 1'b0);
    eval_channel(CH_W'(2), 1'b1, '0);
    eval_channel(CH_W'(2), 1'b0, '1);
    // above rule at full-scale sample
    set_channel(CH_W'(3), RULE_ABOVE, RULE_ABOVE, 32'd1023, '0, 1'b0);
    eval_channel(CH_W'(3), 1'b1, '1);
    // unknown rule still compares against the target
    set_channel(CH_W'(4), RULE_NONE, RULE_NONE, '0, 5, 1'b0);
    eval_channel(CH_W'(4), 1'b0, '0);
    eval_channel(CH_W'(4), 1'b1, '1);
    // all-ones set, then kill and read back; set of an out-of-range channel; evaluate channel 0
    set_channel(CH_W'(5), RULE_NONE, RULE_NONE, '1, '1, 1'b1);
    do_op(OP_KILL, CH_W'(5));
    do_op(OP_READ, CH_W'(5));
    set_channel(CH_W'(NUM_CHANNELS), RULE_TIMER, RULE_TIMER, 1, 1, 1'b1);
    clock_ms += 1000;
    eval_channel(CH_W'(0), 1'b1, '0);
  endtask

  // random traffic until enough in-range requests went in
  task automatic test_random_traffic(input int items);
    int goal;
    goal = requests_in_range + items;
    while (requests_in_range < goal) begin
      if ($urandom_range(0, 99) < 15) send_request(noise_request());
      else run_sequence();
    end
  endtask

  // random traffic with no gaps on either side
  task automatic test_back_to_back();
    steady = 1'b1;
    test_random_traffic(STEADY_ITEMS);
    steady = 1'b0;
  endtask

  // result side stalls
  always @(posedge clk) begin
    if (steady) begin
      out_ready  <= 1'b1;
      ready_hold <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (out_ready && $urandom_range(0, 3) == 0) begin
      out_ready  <= 1'b0;
      ready_hold <= idle_length();
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic void compare_field(string name, logic [DATA_W-1:0] exp_val,
                                        logic [DATA_W-1:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s: expected %0h, actual %0h", name, exp_val, act_val);
      mismatches++;
    end
  endfunction

  // compare each status with the oldest prediction
  always @(posedge clk) begin : check_status
    status_t expected;
    if (rst_n && out_valid && out_ready) begin
      if (pending_status.size() == 0) begin
        $error("status for channel %0d with no request outstanding", out_channel_out);
        mismatches++;
      end else begin
        expected = pending_status.pop_front();
        compare_field("channel_out", DATA_W'(expected.channel), DATA_W'(out_channel_out));
        compare_field("active", DATA_W'(expected.active), DATA_W'(out_active));
        compare_field("out_level", DATA_W'(expected.level), DATA_W'(out_out_level));
        compare_field("cur_state", DATA_W'(expected.state), DATA_W'(out_cur_state));
        compare_field("rule_on", DATA_W'(expected.rule_on), DATA_W'(out_rule_on));
        compare_field("rule_off", DATA_W'(expected.rule_off), DATA_W'(out_rule_off));
        compare_field("target_on", expected.target_on, out_target_on);
        compare_field("target_off", expected.target_off, out_target_off);
        compare_field("progress", expected.progress, out_progress);
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // test sequence
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_readback();
    test_rule_corners();
    test_back_to_back();
    test_random_traffic(RANDOM_ITEMS);
    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
